### rtl/fbx_pkg.sv
// Package for the frame builder with four-lane XOR checksum.
// Holds the queue entry type, frame constants, register indexes and header byte selection.
// No dependencies.
package fbx_pkg;

  localparam int LEN_W          = 16;
  localparam int BYTE_W         = 8;
  localparam int ADDR_W         = 48;
  localparam int LANES_W        = 32;
  localparam int CFG_INDEX_W    = 1;
  localparam int STEP_W         = 5;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h10;
  localparam logic [BYTE_W-1:0] START_BYTE    = 8'h11;

  localparam logic [STEP_W-1:0] PREAMBLE_LEN = 5'd7;
  localparam logic [STEP_W-1:0] DEST_FIRST   = 5'd8;
  localparam logic [STEP_W-1:0] SRC_FIRST    = 5'd14;
  localparam logic [STEP_W-1:0] LEN_HI_STEP  = 5'd20;
  localparam logic [STEP_W-1:0] HDR_LAST     = 5'd21;
  localparam logic [STEP_W-1:0] CSUM_LAST    = 5'd3;

  localparam logic [1:0] DATA_LANE_START = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEST_ADDRESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SRC_ADDRESS  = 1'b1;

  typedef struct packed {
    logic              hdr;
    logic              dat;
    logic              csum;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] pbyte;
  } qent_t;

  function automatic logic [BYTE_W-1:0] addr_byte(input logic [ADDR_W-1:0] a,
                                                  input logic [2:0] i);
    logic [BYTE_W-1:0] b;
    case (i)
      3'd0:    b = a[47:40];
      3'd1:    b = a[39:32];
      3'd2:    b = a[31:24];
      3'd3:    b = a[23:16];
      3'd4:    b = a[15:8];
      3'd5:    b = a[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [STEP_W-1:0] step,
                                                 input logic [ADDR_W-1:0] dest,
                                                 input logic [ADDR_W-1:0] src,
                                                 input logic [LEN_W-1:0]  len);
    logic [STEP_W-1:0] d_idx;
    logic [STEP_W-1:0] s_idx;
    logic [BYTE_W-1:0] b;
    d_idx = step - DEST_FIRST;
    s_idx = step - SRC_FIRST;
    if (step < PREAMBLE_LEN) begin
      b = PREAMBLE_BYTE;
    end else if (step < DEST_FIRST) begin
      b = START_BYTE;
    end else if (step < SRC_FIRST) begin
      b = addr_byte(dest, d_idx[2:0]);
    end else if (step < LEN_HI_STEP) begin
      b = addr_byte(src, s_idx[2:0]);
    end else if (step == LEN_HI_STEP) begin
      b = len[15:8];
    end else begin
      b = len[7:0];
    end
    return b;
  endfunction

endpackage

### rtl/fbx_if.sv
// Channel interfaces of the frame builder: input, result and configuration write.
// Depends on fbx_pkg for field widths.
interface fbx_in_if import fbx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LEN_W-1:0]  payload_length;
  logic [BYTE_W-1:0] payload_byte;
  logic              frame_end;
  modport source (output valid, payload_length, payload_byte, frame_end, input ready);
  modport sink   (input valid, payload_length, payload_byte, frame_end, output ready);
endinterface

interface fbx_out_if import fbx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              run_last;
  logic              frame_last;
  modport source (output valid, frame_byte, run_last, frame_last, input ready);
  modport sink   (input valid, frame_byte, run_last, frame_last, output ready);
endinterface

interface fbx_cfg_if import fbx_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [ADDR_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/fbx_front.sv
// Front end of the frame builder: accepts input words and classifies each one.
// Depends on fbx_pkg and fbx_if; feeds fbx_queue.
module fbx_front import fbx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fbx_in_if.sink      in_ch,
  input  logic        q_full,
  output logic        q_push,
  output qent_t       q_wdata
);

  logic inside_r;
  logic inside_nxt;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.len   = in_ch.payload_length;
    q_wdata.pbyte = in_ch.payload_byte;
    q_wdata.hdr   = !inside_r;
    if (!inside_r && (in_ch.payload_length == '0)) begin
      q_wdata.dat = 1'b0;
      q_wdata.csum = 1'b1;
      inside_nxt   = 1'b0;
    end else begin
      q_wdata.dat  = 1'b1;
      q_wdata.csum = in_ch.frame_end;
      inside_nxt   = !in_ch.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (q_push) begin
      inside_r <= inside_nxt;
    end
  end

endmodule

### rtl/fbx_queue.sv
// Short queue of classified words between the front and back ends.
// Depends on fbx_pkg for the entry type.
module fbx_queue import fbx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wdata,
  input  logic  pop,
  output logic  full,
  output logic  rvalid,
  output qent_t rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  qent_t         mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign rvalid = (count_r != '0);
  assign rdata  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        mem_r[wptr_r] <= wdata;
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

### rtl/fbx_back.sv
// Back end of the frame builder: sequences header, data and checksum bytes per queue entry.
// Depends on fbx_pkg and fbx_if; reads fbx_queue and drives the output register.
module fbx_back import fbx_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  qent_t             q_rdata,
  output logic              q_pop,
  input  logic [ADDR_W-1:0] dest_addr,
  input  logic [ADDR_W-1:0] src_addr,
  fbx_out_if.source         out_ch
);

  typedef enum logic [1:0] {PH_HDR, PH_DAT, PH_CSUM} phase_t;

  phase_t             ph_r, ph_nxt, cur_ph;
  logic               busy_r, busy_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt, cur_cnt;
  logic [LANES_W-1:0] lanes_r, lanes_nxt;
  logic [1:0]         dli_r, dli_nxt;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic               run_last_r, run_last_nxt;
  logic               frame_last_r, frame_last_nxt;
  logic [1:0]         lane;
  logic               do_fold;
  logic               adv, emit;

  assign adv   = !out_valid_r || out_ch.ready;
  assign emit  = q_valid && adv;
  assign q_pop = emit && run_last_nxt;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = byte_r;
  assign out_ch.run_last   = run_last_r;
  assign out_ch.frame_last = frame_last_r;

  always_comb begin
    if (busy_r) begin
      cur_ph  = ph_r;
      cur_cnt = cnt_r;
    end else begin
      cur_ph  = q_rdata.hdr ? PH_HDR : (q_rdata.dat ? PH_DAT : PH_CSUM);
      cur_cnt = '0;
    end
    busy_nxt       = 1'b1;
    ph_nxt         = cur_ph;
    cnt_nxt        = cur_cnt + 1'b1;
    dli_nxt        = dli_r;
    lane           = cur_cnt[1:0];
    do_fold        = 1'b0;
    byte_nxt       = '0;
    run_last_nxt   = 1'b0;
    frame_last_nxt = 1'b0;
    unique case (cur_ph)
      PH_HDR: begin
        byte_nxt = hdr_byte(cur_cnt, dest_addr, src_addr, q_rdata.len);
        do_fold  = 1'b1;
        if (cur_cnt == HDR_LAST) begin
          ph_nxt  = q_rdata.dat ? PH_DAT : PH_CSUM;
          cnt_nxt = '0;
        end
      end
      PH_DAT: begin
        byte_nxt = q_rdata.pbyte;
        lane     = dli_r;
        do_fold  = 1'b1;
        dli_nxt  = dli_r + 1'b1;
        cnt_nxt  = '0;
        if (q_rdata.csum) begin
          ph_nxt = PH_CSUM;
        end else begin
          busy_nxt     = 1'b0;
          run_last_nxt = 1'b1;
        end
      end
      PH_CSUM: begin
        byte_nxt = lanes_r[{~cur_cnt[1:0], 3'b000} +: BYTE_W];
        if (cur_cnt == CSUM_LAST) begin
          busy_nxt       = 1'b0;
          run_last_nxt   = 1'b1;
          frame_last_nxt = 1'b1;
        end
      end
      default: begin
        busy_nxt = 1'b0;
      end
    endcase
    if (frame_last_nxt) begin
      lanes_nxt = '0;
      dli_nxt   = DATA_LANE_START;
    end else if (do_fold) begin
      lanes_nxt = lanes_r ^ ({{(LANES_W - BYTE_W){1'b0}}, byte_nxt} << {~lane, 3'b000});
    end else begin
      lanes_nxt = lanes_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lanes_r     <= '0;
      dli_r       <= DATA_LANE_START;
      ph_r        <= PH_HDR;
      cnt_r       <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= q_valid;
      end
      if (emit) begin
        busy_r       <= busy_nxt;
        ph_r         <= ph_nxt;
        cnt_r        <= cnt_nxt;
        lanes_r      <= lanes_nxt;
        dli_r        <= dli_nxt;
        byte_r       <= byte_nxt;
        run_last_r   <= run_last_nxt;
        frame_last_r <= frame_last_nxt;
      end
    end
  end

endmodule

### rtl/frame_builder_xor_checksum.sv
// Top level of the frame builder with four-lane XOR checksum: configuration registers,
// front end, queue and back end. Depends on fbx_pkg, fbx_if, fbx_front, fbx_queue, fbx_back.
//
// Each input word yields its frame bytes one per cycle on the output channel, as long as the
// receiver holds ready. A word inside a frame yields one byte, the first word of a frame yields
// 23 bytes (22 header bytes and its payload byte), and a word with frame_end adds 4 checksum
// bytes; an empty-payload first word yields 26. The back end has a single output byte register.
// Input words are accepted while the back end is busy until the queue of QUEUE_DEPTH entries is
// full, and the output register lets a new byte load in the same cycle the waiting one is taken.
module frame_builder_xor_checksum import fbx_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fbx_in_if.sink     in_ch,
  fbx_out_if.source  out_ch,
  fbx_cfg_if.sink    cfg_ch
);

  logic [ADDR_W-1:0] dest_r;
  logic [ADDR_W-1:0] src_r;
  logic              q_full;
  logic              q_push;
  logic              q_pop;
  logic              q_valid;
  qent_t             q_wdata;
  qent_t             q_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r <= '0;
      src_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DEST_ADDRESS: dest_r <= cfg_ch.data;
        CFG_SRC_ADDRESS:  src_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  fbx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  fbx_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .full   (q_full),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  fbx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .dest_addr (dest_r),
    .src_addr  (src_r),
    .out_ch    (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.frame_last |-> out_ch.run_last)
    else $error("frame_last word without run_last");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for frame_builder_xor_checksum: drives payload words and address writes, and
// predicts every frame byte with its flags, including the four-lane XOR checksum.
// Depends on fbx_pkg, the fbx_if channel interfaces and the block's RTL.
module tb;
  import fbx_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              run_last;
    logic              frame_last;
  } frame_word_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVE} rx_mode_t;

  class frame_scoreboard;
    logic [ADDR_W-1:0]  dest_addr;
    logic [ADDR_W-1:0]  src_addr;
    logic [LANES_W-1:0] lanes;
    logic [1:0]         data_lane;
    bit                 open_frame;
    frame_word_t        expected_bytes[$];
    frame_word_t        held;
    bit                 have_held;
    int                 errors;
    int                 words_in;
    int                 frames_done;
    int                 bytes_checked;

    function new();
      dest_addr     = '0;
      src_addr      = '0;
      lanes         = '0;
      data_lane     = DATA_LANE_START;
      open_frame    = 1'b0;
      have_held     = 1'b0;
      errors        = 0;
      words_in      = 0;
      frames_done   = 0;
      bytes_checked = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] val);
      case (idx)
        CFG_DEST_ADDRESS: dest_addr = val;
        CFG_SRC_ADDRESS:  src_addr  = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void append_word(frame_word_t w);
      expected_bytes = {expected_bytes, w};
    endfunction

    function void emit(logic [BYTE_W-1:0] b, logic flast);
      if (have_held) append_word(held);
      held.frame_byte = b;
      held.run_last   = 1'b0;
      held.frame_last = flast;
      have_held       = 1'b1;
    endfunction

    function void add_byte(int lane, logic [BYTE_W-1:0] b);
      lanes[(3 - lane) * BYTE_W +: BYTE_W] = lanes[(3 - lane) * BYTE_W +: BYTE_W] ^ b;
      emit(b, 1'b0);
    endfunction

    function void add_data(logic [BYTE_W-1:0] b);
      add_byte(int'(data_lane), b);
      data_lane = data_lane + 2'd1;
    endfunction

    function void close_frame();
      int k;
      for (k = 0; k < 4; k++) emit(lanes[(3 - k) * BYTE_W +: BYTE_W], k == 3);
      lanes       = '0;
      data_lane   = DATA_LANE_START;
      open_frame  = 1'b0;
      frames_done++;
    endfunction

    function void note_word(logic [LEN_W-1:0] len, logic [BYTE_W-1:0] pbyte, logic fend);
      int i;
      words_in++;
      if (!open_frame) begin
        lanes     = '0;
        data_lane = DATA_LANE_START;
        for (i = 0; i < 7; i++) add_byte(i % 4, PREAMBLE_BYTE);
        add_byte(3, START_BYTE);
        for (i = 0; i < 6; i++) add_byte(i % 4, dest_addr[(5 - i) * BYTE_W +: BYTE_W]);
        for (i = 0; i < 6; i++) add_byte((i + 2) % 4, src_addr[(5 - i) * BYTE_W +: BYTE_W]);
        add_byte(0, len[15:8]);
        add_byte(1, len[7:0]);
        if (len == '0) begin
          close_frame();
        end else begin
          open_frame = 1'b1;
          add_data(pbyte);
          if (fend) close_frame();
        end
      end else begin
        add_data(pbyte);
        if (fend) close_frame();
      end
      held.run_last = 1'b1;
      append_word(held);
      have_held = 1'b0;
    endfunction

    function void check_byte(frame_word_t got);
      frame_word_t want;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected frame byte %h run_last %b frame_last %b", $time,
                 got.frame_byte, got.run_last, got.frame_last);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (got !== want) begin
        $display("%0t: expected byte/run_last/frame_last %h/%b/%b, actual %h/%b/%b",
                 $time, want.frame_byte, want.run_last, want.frame_last,
                 got.frame_byte, got.run_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  fbx_in_if  in_ch();
  fbx_out_if out_ch();
  fbx_cfg_if cfg_ch();

  frame_builder_xor_checksum DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard board = new();

  int       tx_burst   = 0;
  bit       tx_holding = 1'b0;
  int       settings   = 1;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;
  int       cyc        = 0;
  int       idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'(2'($urandom_range(0, 3)));
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: out_ch.ready <= (cyc % 7) < 4;
      RX_STARVE:   out_ch.ready <= (cyc % 16) == 0;
      default:     out_ch.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_byte({out_ch.frame_byte, out_ch.run_last, out_ch.frame_last});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic send_word(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] pbyte,
                           input logic fend);
    in_ch.valid          <= 1'b1;
    in_ch.payload_length <= len;
    in_ch.payload_byte   <= pbyte;
    in_ch.frame_end      <= fend;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_word(len, pbyte, fend);
    if (tx_burst > 0) begin
      tx_burst--;
      tx_holding = 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
      tx_holding = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      tx_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end
  endtask

  task automatic send_frame(input int nbytes, input logic [LEN_W-1:0] first_len);
    int i;
    for (i = 0; i < nbytes; i++) begin
      send_word((i == 0) ? first_len : 16'($urandom), 8'($urandom), i == nbytes - 1);
    end
  endtask

  task automatic random_traffic(input int target);
    int count;
    int pick;
    int n;
    count = 0;
    while (count < target) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_word(16'd0, 8'($urandom), 1'($urandom));
        count++;
      end else begin
        n = (pick == 9) ? $urandom_range(11, 40) : $urandom_range(1, 8);
        send_frame(n, $urandom_range(0, 1) ? 16'(n) : 16'($urandom_range(1, 65535)));
        count += n;
      end
    end
  endtask

  task automatic settle();
    if (tx_holding) begin
      in_ch.valid <= 1'b0;
      tx_holding = 1'b0;
    end
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_addrs(input logic [ADDR_W-1:0] dest, input logic [ADDR_W-1:0] src);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_DEST_ADDRESS;
    cfg_ch.data  <= dest;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(CFG_DEST_ADDRESS, dest);
    cfg_ch.index <= CFG_SRC_ADDRESS;
    cfg_ch.data  <= src;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_reg(CFG_SRC_ADDRESS, src);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.payload_length <= '0;
    in_ch.payload_byte   <= '0;
    in_ch.frame_end      <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= CFG_DEST_ADDRESS;
    cfg_ch.data          <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(16'd0, 8'hFF, 1'b1);
    send_word(16'd0, 8'h00, 1'b0);
    send_word(16'hFFFF, 8'hFF, 1'b1);
    send_word(16'd1, 8'h00, 1'b1);
    send_word(16'h8000, 8'h00, 1'b0);
    send_word(16'h0000, 8'hFF, 1'b0);
    send_word(16'hFFFF, 8'hAA, 1'b0);
    send_word(16'h5555, 8'h55, 1'b0);
    send_word(16'hAAAA, 8'h01, 1'b0);
    send_word(16'h1234, 8'h80, 1'b1);
    send_word(16'd2, 8'h12, 1'b0);
    send_word(16'd2, 8'h34, 1'b1);
    settle();

    write_addrs({ADDR_W{1'b1}}, {ADDR_W{1'b1}});
    send_word(16'd0, 8'h5A, 1'b0);
    send_word(16'h0100, 8'h7F, 1'b1);
    send_frame(5, 16'd3);
    random_traffic(30);
    send_word(16'd4, 8'hC3, 1'b0);
    settle();

    write_addrs(48'($urandom_range(0, 1) ? {$urandom, $urandom} : 64'h0),
                48'({$urandom, $urandom}));
    send_word(16'($urandom), 8'h3C, 1'b1);
    random_traffic(45);
    settle();

    write_addrs(48'h0123_4567_89AB, 48'hFEDC_BA98_7654);
    random_traffic(45);
    settle();

    write_addrs('0, {ADDR_W{1'b1}});
    random_traffic(45);
    settle();

    $display("tb: %0d input words, %0d frames, %0d frame bytes checked", board.words_in,
             board.frames_done, board.bytes_checked);
    $display("tb: %0d address settings, empty and single-word frames, length mismatches",
             settings);
    if (board.pending() != 0) begin
      $display("%0t: %0d expected frame bytes never arrived", $time, board.pending());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
